FILE: hw/rtl/dmh_pkg.sv
// Package of the deadline event queue: payload types, status and mode codes,
// and the sizing constants of the heap. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmh_pkg;

  // Requested heap depth and the usable capacity (slots are unique, 6 bits).
  localparam int QUEUE_DEPTH = 64;
  localparam int SLOT_W      = 6;
  localparam int SLOT_N      = 1 << SLOT_W;
  localparam int HEAP_CAP    = (QUEUE_DEPTH < SLOT_N) ? QUEUE_DEPTH : SLOT_N;
  localparam int IDX_W       = $clog2(HEAP_CAP);
  localparam int CNT_W       = $clog2(HEAP_CAP + 1);
  localparam int CHILD_W     = IDX_W + 2;

  // Request modes.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_PUMP   = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_FIRED   = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [31:0]       deadline;
    logic [SLOT_W-1:0] event_slot;
    logic [31:0]       now_time;
  } dmh_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] fired_slot;
    logic [31:0]       fired_deadline;
    logic              last_result;
  } dmh_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dmh_channels.sv
// Valid/ready channel interfaces for requests and results of the event queue.
// Depends on dmh_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface dmh_in_if;
  import dmh_pkg::*;

  logic    valid;
  logic    ready;
  dmh_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dmh_out_if;
  import dmh_pkg::*;

  logic     valid;
  logic     ready;
  dmh_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/deadline_min_heap_event_queue_unit.sv
// Deadline event queue: binary min-heap of (deadline, slot) events with an
// active-slot bitmap, driven by a small sequencer around one key comparator.
// Depends on dmh_pkg and the channel interfaces in dmh_channels.sv.
//
// Usage: requests arrive on in_i (insert, pump or remove) and are taken only
// while the sequencer is idle. Results leave on out_o through an output
// register; every request gives one result, a pump gives one per fired event,
// and the last result of a request has last_result set.
// Sequencing: a request is decoded and its result is then loaded into the output
// register; a refusal, a miss or an empty pump does nothing more. Each heap level
// takes a registered memory read and a compare on the way up, and a read, a
// child select and a compare on the way down, all sharing one order-key
// comparator, and a sift ends by writing the moving entry into the final hole.
// A remove first reads the slot position table and ends at once when it takes
// the last entry; a pump sifts down once per fired event and ends with a final
// root check. in_i.ready returns once the sequencer is back in idle.
// Reset clears the entry count and the active bitmap; the heap memory and the
// slot position table need no clearing since only live entries are read.
// When the receiver stalls, a finished result waits in the output register;
// a pump holds before the next pop until the previous result is taken.
`timescale 1ns / 1ps
`default_nettype none

module deadline_min_heap_event_queue_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dmh_in_if.sink    in_i,
  dmh_out_if.source out_o
);
  import dmh_pkg::*;

  localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;
  localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

  typedef struct packed {
    logic [31:0]       deadline;
    logic [SLOT_W-1:0] slot;
  } heap_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RM_POS,
    S_RM_TAKE,
    S_CHECK,
    S_PUMP_RD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_SEL,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_e;

  // Order-preserving integer key of an IEEE single pattern.
  function automatic logic [31:0] order_key(input logic [31:0] bits);
    logic [31:0] b;
    b = (bits == NEG_ZERO) ? 32'h0 : bits;
    return b[31] ? ~b : (b | NEG_ZERO);
  endfunction

  function automatic logic is_nan(input logic [31:0] bits);
    return bits[30:0] > INF_MAG;
  endfunction

  state_e                state_q, state_d;
  dmh_in_t               req_q, req_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [SLOT_N-1:0]     active_q, active_d;
  logic [IDX_W-1:0]      pos_q, pos_d;
  heap_entry_t           mv_q, mv_d;
  heap_entry_t           child_q, child_d;
  logic [IDX_W-1:0]      child_pos_q, child_pos_d;
  logic [1:0]            res_status_q, res_status_d;
  logic [SLOT_W-1:0]     res_slot_q, res_slot_d;
  logic [31:0]           res_dl_q, res_dl_d;
  logic                  have_pend_q, have_pend_d;
  logic                  out_valid_q, out_valid_d;
  dmh_out_t              out_q, out_d;

  // Heap memory, slot position table and their registered read data.
  heap_entry_t           heap_mem [HEAP_CAP];
  logic [IDX_W-1:0]      ptab_mem [SLOT_N];
  heap_entry_t           rda_q, rdb_q;
  logic [IDX_W-1:0]      ptab_rd_q;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  heap_entry_t           mem_wdata;
  logic                  rd_en;
  logic [IDX_W-1:0]      rda_addr, rdb_addr;
  logic                  ptab_re;

  // Shared comparator operands and result.
  logic [31:0]           cmp_a, cmp_b;
  logic                  cmp_lt;

  logic                  out_free;
  logic [CHILD_W-1:0]    left_w, right_w, count_w;
  logic [IDX_W-1:0]      parent_idx, last_idx;

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign out_free    = !out_valid_q || out_o.ready;

  assign left_w     = CHILD_W'({pos_q, 1'b1});
  assign right_w    = left_w + CHILD_W'(1);
  assign count_w    = CHILD_W'(count_q);
  assign parent_idx = (pos_q - IDX_W'(1)) >> 1;
  assign last_idx   = IDX_W'(count_q - CNT_W'(1));

  // Operand selection for the single order-key comparator.
  always_comb begin
    unique case (state_q)
      S_DN_SEL: begin
        cmp_a = rda_q.deadline;
        cmp_b = rdb_q.deadline;
      end
      S_DN_CMP: begin
        cmp_a = child_q.deadline;
        cmp_b = mv_q.deadline;
      end
      S_CHECK: begin
        cmp_a = rda_q.deadline;
        cmp_b = req_q.now_time;
      end
      default: begin
        cmp_a = mv_q.deadline;
        cmp_b = rda_q.deadline;
      end
    endcase
  end

  assign cmp_lt = order_key(cmp_a) < order_key(cmp_b);

  // Sequencer next-state, memory control and result loading.
  always_comb begin
    logic out_load;
    logic out_last;

    state_d      = state_q;
    req_d        = req_q;
    count_d      = count_q;
    active_d     = active_q;
    pos_d        = pos_q;
    mv_d         = mv_q;
    child_d      = child_q;
    child_pos_d  = child_pos_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_dl_d     = res_dl_q;
    have_pend_d  = have_pend_q;
    mem_we       = 1'b0;
    mem_waddr    = pos_q;
    mem_wdata    = mv_q;
    rd_en        = 1'b0;
    rda_addr     = '0;
    rdb_addr     = last_idx;
    ptab_re      = 1'b0;
    out_load     = 1'b0;
    out_last     = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          req_d   = in_i.data;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        have_pend_d = 1'b0;
        unique case (req_q.mode)
          MODE_INSERT: begin
            if (count_q >= CNT_W'(HEAP_CAP) || active_q[req_q.event_slot] ||
                is_nan(req_q.deadline)) begin
              res_status_d = ST_REFUSED;
              res_slot_d   = req_q.event_slot;
              res_dl_d     = '0;
              state_d      = S_DONE;
            end else begin
              mv_d.deadline = req_q.deadline;
              mv_d.slot     = req_q.event_slot;
              pos_d         = IDX_W'(count_q);
              count_d       = count_q + CNT_W'(1);
              active_d[req_q.event_slot] = 1'b1;
              res_status_d  = ST_DONE;
              res_slot_d    = req_q.event_slot;
              res_dl_d      = req_q.deadline;
              state_d       = S_UP_RD;
            end
          end
          MODE_PUMP: begin
            if (count_q == '0 || is_nan(req_q.now_time)) begin
              res_status_d = ST_NONE;
              res_slot_d   = '0;
              res_dl_d     = '0;
              state_d      = S_DONE;
            end else begin
              rd_en    = 1'b1;
              rda_addr = '0;
              rdb_addr = last_idx;
              state_d  = S_CHECK;
            end
          end
          MODE_REMOVE: begin
            if (!active_q[req_q.event_slot]) begin
              res_status_d = ST_NONE;
              res_slot_d   = req_q.event_slot;
              res_dl_d     = '0;
              state_d      = S_DONE;
            end else begin
              ptab_re = 1'b1;
              state_d = S_RM_POS;
            end
          end
          default: begin
            res_status_d = ST_REFUSED;
            res_slot_d   = '0;
            res_dl_d     = '0;
            state_d      = S_DONE;
          end
        endcase
      end

      // Fetch the entry to remove and the last entry.
      S_RM_POS: begin
        rd_en    = 1'b1;
        rda_addr = ptab_rd_q;
        rdb_addr = last_idx;
        pos_d    = ptab_rd_q;
        state_d  = S_RM_TAKE;
      end

      S_RM_TAKE: begin
        res_status_d = ST_DONE;
        res_slot_d   = req_q.event_slot;
        res_dl_d     = rda_q.deadline;
        active_d[req_q.event_slot] = 1'b0;
        count_d      = count_q - CNT_W'(1);
        if (pos_q == last_idx) begin
          state_d = S_DONE;
        end else begin
          mv_d    = rdb_q;
          state_d = S_UP_RD;
        end
      end

      // Root is in rda, last entry in rdb. Emit the pending event, whose
      // last flag depends on whether the current root is due as well.
      S_CHECK: begin
        if (!have_pend_q || out_free) begin
          if (have_pend_q) begin
            out_load = 1'b1;
            out_last = !cmp_lt;
          end
          if (cmp_lt) begin
            res_status_d = ST_FIRED;
            res_slot_d   = rda_q.slot;
            res_dl_d     = rda_q.deadline;
            have_pend_d  = 1'b1;
            active_d[rda_q.slot] = 1'b0;
            count_d      = count_q - CNT_W'(1);
            if (count_q == CNT_W'(1)) begin
              state_d = S_DONE;
            end else begin
              mv_d    = rdb_q;
              pos_d   = '0;
              state_d = S_DN_RD;
            end
          end else if (have_pend_q) begin
            state_d = S_IDLE;
          end else begin
            res_status_d = ST_NONE;
            res_slot_d   = '0;
            res_dl_d     = '0;
            state_d      = S_DONE;
          end
        end
      end

      S_PUMP_RD: begin
        if (count_q == '0) begin
          state_d = S_DONE;
        end else begin
          rd_en    = 1'b1;
          rda_addr = '0;
          rdb_addr = last_idx;
          state_d  = S_CHECK;
        end
      end

      // Sift up: read the parent of the hole.
      S_UP_RD: begin
        if (pos_q == '0) begin
          state_d = S_DN_RD;
        end else begin
          rd_en    = 1'b1;
          rda_addr = parent_idx;
          state_d  = S_UP_CMP;
        end
      end

      // Moving entry strictly earlier than the parent: parent drops into the hole.
      S_UP_CMP: begin
        if (cmp_lt) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = rda_q;
          pos_d     = parent_idx;
          state_d   = S_UP_RD;
        end else begin
          state_d = S_DN_RD;
        end
      end

      // Sift down: read both children of the hole.
      S_DN_RD: begin
        if (left_w >= count_w) begin
          state_d = S_PLACE;
        end else begin
          rd_en    = 1'b1;
          rda_addr = IDX_W'(left_w);
          rdb_addr = IDX_W'(right_w);
          state_d  = S_DN_SEL;
        end
      end

      // The right child wins unless the left one is strictly earlier.
      S_DN_SEL: begin
        if (right_w < count_w && !cmp_lt) begin
          child_d     = rdb_q;
          child_pos_d = IDX_W'(right_w);
        end else begin
          child_d     = rda_q;
          child_pos_d = IDX_W'(left_w);
        end
        state_d = S_DN_CMP;
      end

      S_DN_CMP: begin
        if (cmp_lt) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = child_q;
          pos_d     = child_pos_q;
          state_d   = S_DN_RD;
        end else begin
          state_d = S_PLACE;
        end
      end

      // Drop the moving entry into the final hole.
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = mv_q;
        state_d   = (req_q.mode == MODE_PUMP) ? S_PUMP_RD : S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_last    = 1'b1;
          have_pend_d = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // Output register.
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d.status         = res_status_q;
      out_d.fired_slot     = res_slot_q;
      out_d.fired_deadline = res_dl_q;
      out_d.last_result    = out_last;
      out_valid_d          = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      active_q    <= '0;
      have_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      active_q    <= active_d;
      have_pend_q <= have_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    pos_q        <= pos_d;
    mv_q         <= mv_d;
    child_q      <= child_d;
    child_pos_q  <= child_pos_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_dl_q     <= res_dl_d;
    out_q        <= out_d;
  end

  // Heap memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rda_q <= heap_mem[rda_addr];
      rdb_q <= heap_mem[rdb_addr];
    end
  end

  // Slot position table follows every heap write.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ptab_mem[mem_wdata.slot] <= mem_waddr;
    end
    if (ptab_re) begin
      ptab_rd_q <= ptab_mem[req_q.event_slot];
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the deadline event queue: drives insert, pump and
// remove requests and checks every result against an in-bench heap predictor.
// Depends on dmh_pkg, the channel interfaces and deadline_min_heap_event_queue_unit.
`timescale 1ns / 1ps

module tb_top;
  import dmh_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int MIX_ITEMS   = 130;
  localparam int SETTLE_WAIT = 40;

  // Predicts the results of each accepted request from its own heap copy and
  // keeps them in order until the block delivers them.
  class event_queue_scoreboard;
    bit [31:0]       heap_dl[HEAP_CAP];
    bit [SLOT_W-1:0] heap_id[HEAP_CAP];
    int unsigned     live;
    bit [SLOT_N-1:0] active_map;
    dmh_out_t        awaited[$];
    int unsigned     errors;

    function new();
      live = 0;
      active_map = '0;
      errors = 0;
    endfunction

    // Maps an IEEE single pattern onto an unsigned key with the same order.
    static function bit [31:0] order_key(bit [31:0] bits);
      if (bits == 32'h8000_0000) begin
        bits = '0;
      end
      return bits[31] ? ~bits : (bits | 32'h8000_0000);
    endfunction

    static function bit is_nan(bit [31:0] bits);
      return (bits & 32'h7FFF_FFFF) > 32'h7F80_0000;
    endfunction

    function bit earlier(int unsigned a, int unsigned b);
      return order_key(heap_dl[a]) < order_key(heap_dl[b]);
    endfunction

    function void exchange_pair(int unsigned a, int unsigned b);
      bit [31:0]       dl;
      bit [SLOT_W-1:0] id;
      dl = heap_dl[a];
      id = heap_id[a];
      heap_dl[a] = heap_dl[b];
      heap_id[a] = heap_id[b];
      heap_dl[b] = dl;
      heap_id[b] = id;
    endfunction

    // Moves the entry at pos up while it beats its parent, then down; on equal
    // children the right one is taken.
    function void restore_order(int unsigned count, int unsigned pos);
      int unsigned parent, left, right, child;
      while (pos != 0) begin
        parent = (pos - 1) / 2;
        if (!earlier(pos, parent)) break;
        exchange_pair(pos, parent);
        pos = parent;
      end
      forever begin
        left = pos * 2 + 1;
        right = left + 1;
        child = left;
        if (left >= count) break;
        if (right < count && !earlier(left, right)) child = right;
        if (!earlier(child, pos)) break;
        exchange_pair(pos, child);
        pos = child;
      end
    endfunction

    function void take_out(int unsigned pos);
      int unsigned last;
      last = live - 1;
      active_map[heap_id[pos]] = 1'b0;
      live = last;
      if (pos != last) begin
        heap_dl[pos] = heap_dl[last];
        heap_id[pos] = heap_id[last];
        restore_order(last, pos);
      end
    endfunction

    function void await_result(logic [1:0] status, logic [SLOT_W-1:0] id,
                               logic [31:0] dl, logic last);
      dmh_out_t res;
      res.status = status;
      res.fired_slot = id;
      res.fired_deadline = dl;
      res.last_result = last;
      awaited.push_back(res);
    endfunction

    // Notes an accepted request: updates the heap copy and queues its results.
    function void note_request(dmh_in_t req);
      int unsigned fired;
      bit          found;
      bit [31:0]   gone;
      fired = 0;
      found = 1'b0;
      case (req.mode)
        MODE_INSERT: begin
          if (live >= HEAP_CAP || active_map[req.event_slot] || is_nan(req.deadline)) begin
            await_result(ST_REFUSED, req.event_slot, '0, 1'b1);
          end else begin
            heap_dl[live] = req.deadline;
            heap_id[live] = req.event_slot;
            live++;
            active_map[req.event_slot] = 1'b1;
            restore_order(live, live - 1);
            await_result(ST_DONE, req.event_slot, req.deadline, 1'b1);
          end
        end
        MODE_PUMP: begin
          while (!is_nan(req.now_time) && live != 0 && fired < SLOT_N &&
                 order_key(heap_dl[0]) < order_key(req.now_time)) begin
            await_result(ST_FIRED, heap_id[0], heap_dl[0], 1'b0);
            fired++;
            take_out(0);
          end
          if (fired == 0) begin
            await_result(ST_NONE, '0, '0, 1'b1);
          end else begin
            awaited[awaited.size() - 1].last_result = 1'b1;
          end
        end
        MODE_REMOVE: begin
          for (int unsigned i = 0; i < live && !found; i++) begin
            if (heap_id[i] == req.event_slot) begin
              gone = heap_dl[i];
              take_out(i);
              await_result(ST_DONE, req.event_slot, gone, 1'b1);
              found = 1'b1;
            end
          end
          if (!found) await_result(ST_NONE, req.event_slot, '0, 1'b1);
        end
        default: begin
          await_result(ST_REFUSED, '0, '0, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    // Checks one delivered result against the oldest prediction.
    function void check_result(dmh_out_t got);
      dmh_out_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = awaited.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("fired_slot", 32'(want.fired_slot), 32'(got.fired_slot));
      compare_field("fired_deadline", want.fired_deadline, got.fired_deadline);
      compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dmh_in_if  in_ch ();
  dmh_out_if out_ch ();

  event_queue_scoreboard sb = new();

  // Pacing controls shared by the request and result sides.
  bit          calm = 1'b0;
  bit          rx_steady = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned stall_left = 0;

  deadline_min_heap_event_queue_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: checks accepted results and paces ready, with one long
  // hold-off on request.
  always @(posedge clk_i) begin : result_side
    int unsigned pick;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (rx_steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

  // Ends the run when nothing has been accepted on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("deadline_min_heap_event_queue_unit verification failed");
    $finish;
  end

  // Time values: specials, NaNs, a small pool that forces ties, and raw bits.
  function automatic logic [31:0] pick_time();
    logic [31:0] specials[8] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                 32'hFF80_0000, 32'h0000_0001, 32'h8000_0001,
                                 32'h7F7F_FFFF, 32'hFF7F_FFFF};
    logic [31:0] ties[4] = '{32'h3F80_0000, 32'h4000_0000, 32'hBF80_0000,
                             32'h4120_0000};
    case ($urandom_range(0, 9))
      0:       return specials[$urandom_range(0, 7)];
      1:       return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
      2, 3:    return ties[$urandom_range(0, 3)];
      default: return $urandom();
    endcase
  endfunction

  // Builds a request; fields the mode does not use carry random bits.
  function automatic dmh_in_t build_request(logic [1:0] mode, logic [31:0] dl,
                                            logic [SLOT_W-1:0] id, logic [31:0] now);
    dmh_in_t req;
    req.mode = mode;
    req.deadline = (mode == MODE_INSERT) ? dl : $urandom();
    req.event_slot = (mode == MODE_PUMP) ? SLOT_W'($urandom()) : id;
    req.now_time = (mode == MODE_PUMP) ? now : $urandom();
    return req;
  endfunction

  // Picks a slot whose active bit matches want_active, if there is one.
  function automatic logic [SLOT_W-1:0] pick_slot(bit want_active);
    int unsigned start;
    start = $urandom_range(0, SLOT_N - 1);
    for (int unsigned k = 0; k < SLOT_N; k++) begin
      if (sb.active_map[(start + k) % SLOT_N] == want_active)
        return SLOT_W'((start + k) % SLOT_N);
    end
    return SLOT_W'(start);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one request, waits for it to be taken, then idles for a random gap.
  task automatic offer(input dmh_in_t req);
    int unsigned gap;
    in_ch.data <= req;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_request(req);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_until_settled();
    in_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned fill_order[SLOT_N];
    int unsigned j, tmp, pick;
    logic [SLOT_W-1:0] id;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty heap, bad mode, signed zeros, infinities, NaN refusals,
    // duplicate slot, ties, removes, and pumps at NaN and boundary times.
    offer(build_request(MODE_PUMP, '0, '0, 32'h7F80_0000));
    offer(build_request(MODE_REMOVE, '0, 6'd5, '0));
    offer(build_request(2'd3, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF));
    offer(build_request(MODE_INSERT, 32'h0000_0000, 6'd0, '0));
    offer(build_request(MODE_INSERT, 32'h8000_0000, 6'd63, '0));
    offer(build_request(MODE_INSERT, 32'hFF80_0000, 6'd1, '0));
    offer(build_request(MODE_INSERT, 32'h7F80_0000, 6'd2, '0));
    offer(build_request(MODE_INSERT, 32'h7FC0_0000, 6'd3, '0));
    offer(build_request(MODE_INSERT, 32'hFFFF_FFFF, 6'd4, '0));
    offer(build_request(MODE_INSERT, 32'h3F80_0000, 6'd0, '0));
    offer(build_request(MODE_INSERT, 32'h0000_0001, 6'd5, '0));
    offer(build_request(MODE_INSERT, 32'h8000_0001, 6'd6, '0));
    offer(build_request(MODE_INSERT, 32'h3F80_0000, 6'd7, '0));
    offer(build_request(MODE_INSERT, 32'h3F80_0000, 6'd8, '0));
    offer(build_request(MODE_INSERT, 32'h7F7F_FFFF, 6'd9, '0));
    offer(build_request(MODE_INSERT, 32'hFF7F_FFFF, 6'd10, '0));
    offer(build_request(MODE_REMOVE, '0, 6'd7, '0));
    offer(build_request(MODE_REMOVE, '0, 6'd7, '0));
    offer(build_request(MODE_PUMP, '0, '0, 32'h7FC0_0001));
    offer(build_request(MODE_PUMP, '0, '0, 32'hFF80_0000));
    offer(build_request(MODE_PUMP, '0, '0, 32'h0000_0000));
    offer(build_request(MODE_PUMP, '0, '0, 32'h8000_0000));
    offer(build_request(MODE_PUMP, '0, '0, 32'h7F80_0000));
    offer(build_request(MODE_REMOVE, '0, 6'd2, '0));
    wait_until_settled();

    // Fill every slot in random order, overflow the full heap, then drain part.
    for (int unsigned i = 0; i < SLOT_N; i++) fill_order[i] = i;
    for (int unsigned i = SLOT_N - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = tmp;
    end
    for (int unsigned i = 0; i < SLOT_N; i++)
      offer(build_request(MODE_INSERT, pick_time(), SLOT_W'(fill_order[i]), '0));
    repeat (3) offer(build_request(MODE_INSERT, $urandom(), SLOT_W'($urandom()), '0));
    offer(build_request(MODE_PUMP, '0, '0, pick_time()));
    wait_until_settled();

    // Mixed traffic; it opens with a long result hold-off so the block backs up.
    hold_request = 1'b1;
    for (int n = 0; n < MIX_ITEMS; n++) begin
      calm = (n >= 40 && n < 70);
      rx_steady = calm;
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
        id = pick_slot(($urandom_range(0, 9) < 7) ? 1'b0 : 1'b1);
        offer(build_request(MODE_INSERT, pick_time(), id, '0));
      end else if (pick < 65) begin
        id = pick_slot(($urandom_range(0, 3) != 0) ? 1'b1 : 1'b0);
        offer(build_request(MODE_REMOVE, '0, id, '0));
      end else if (pick < 95) begin
        offer(build_request(MODE_PUMP, '0, '0, pick_time()));
      end else begin
        offer(build_request(2'd3, $urandom(), SLOT_W'($urandom()), $urandom()));
      end
    end
    calm = 1'b0;
    rx_steady = 1'b0;

    wait_until_settled();
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("deadline_min_heap_event_queue_unit verification clean");
    end else begin
      $display("deadline_min_heap_event_queue_unit verification failed");
    end
    $finish;
  end

endmodule
